// ===== src/frx_pkg.sv =====
`default_nettype none
package frx_pkg;

    localparam logic [7:0]  STX_BYTE    = 8'h8F;
    localparam logic [7:0]  ESC_BYTE    = 8'h9F;
    localparam logic [7:0]  TSTX_BYTE   = 8'h81;
    localparam logic [7:0]  TESC_BYTE   = 8'h83;
    localparam logic [15:0] SYNC_LENGTH = 16'h0100;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    localparam int KIND_W    = 2;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_NUM_LO,
        PH_NUM_HI,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_SYNC = 2'd3
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  data;
        logic [15:0] number;
        logic [15:0] length;
    } t_result;

    // CRC-16/CCITT-FALSE, one byte, poly 0x1021, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = {crc[7:0], crc[15:8]} ^ {8'h00, b};
        r = r ^ {12'h000, r[7:4]};
        r = r ^ {r[3:0], 12'h000};
        r = r ^ {3'b000, r[7:0], 5'b00000};
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/frame_receiver_unstuff_crc16_check.sv =====
// Path: an accepted beat is held in the input register, and its result is decoded from it into the output register.
// Throughput: one input beat per cycle while the output side takes its beats.
// A result waiting on the output holds the input register, even for beats with no result.
// Reset (synchronous, active low): hunt for start byte, CRC preset to all ones,
// sync answers not reported, both pipe stages empty.
`default_nettype none
module frame_receiver_unstuff_crc16_check
    import frx_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_wr_en,
    input  wire                    i_cfg_wr_data,
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire [7:0]              i_s_axis_tdata,  // raw_byte
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,  // data, frame_number, frame_length
    output logic [KIND_W-1:0]      o_m_axis_tuser   // kind
);

    logic        r_sync_mode;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;
    t_result     w_res;
    logic        w_advance;

    // advance when the result slot is free or being drained
    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_sync_mode <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    frx_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (r_in_valid && w_advance),
        .i_byte      (r_in_byte),
        .i_sync_mode (r_sync_mode),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.length, r_out.number, r_out.data};
    assign o_m_axis_tuser  = r_out.kind;

endmodule
`default_nettype wire

// ===== src/frx_core.sv =====
`default_nettype none
module frx_core
    import frx_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  wire [7:0]  i_byte,
    input  wire        i_sync_mode,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic        r_esc, n_esc;
    logic [15:0] r_length, n_length;
    logic [15:0] r_number, n_number;
    logic [15:0] r_left, n_left;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_low, n_low;

    always_comb begin
        logic [7:0]  d;
        logic [15:0] word;
        logic        skip;
        n_phase  = r_phase;
        n_esc    = r_esc;
        n_length = r_length;
        n_number = r_number;
        n_left   = r_left;
        n_crc    = r_crc;
        n_low    = r_low;
        o_res    = '0;
        d        = i_byte;
        skip     = 1'b0;

        // undo escaping first; a lone ESC produces nothing
        if (r_esc) begin
            n_esc = 1'b0;
            if (i_byte == TSTX_BYTE) begin
                d = STX_BYTE;
            end else if (i_byte == TESC_BYTE) begin
                d = ESC_BYTE;
            end
        end else if (i_byte == ESC_BYTE) begin
            n_esc = 1'b1;
            skip  = 1'b1;
        end

        word = {d, r_low};

        if (!skip) begin
            case (r_phase)
                PH_HUNT: begin
                    if (d == STX_BYTE) begin
                        n_number = '0;
                        n_length = '0;
                        n_crc    = CRC_INIT;
                        n_phase  = PH_LEN_LO;
                    end
                end
                PH_LEN_LO: begin
                    n_low   = d;
                    n_crc   = crc_byte(r_crc, d);
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_length = word;
                    if (word > 16'd1) begin
                        n_crc   = crc_byte(r_crc, d);
                        n_phase = PH_NUM_LO;
                    end else begin
                        // no number: fold in two zero bytes
                        n_crc   = crc_byte(crc_byte(crc_byte(r_crc, d), 8'h00), 8'h00);
                        n_phase = PH_CRC_LO;
                    end
                end
                PH_NUM_LO: begin
                    n_low   = d;
                    n_crc   = crc_byte(r_crc, d);
                    n_phase = PH_NUM_HI;
                end
                PH_NUM_HI: begin
                    n_number = word;
                    n_crc    = crc_byte(r_crc, d);
                    if (r_length == SYNC_LENGTH) begin
                        n_phase     = PH_HUNT;
                        o_res.valid = i_sync_mode;
                        o_res.kind  = KIND_SYNC;
                    end else begin
                        n_left  = r_length - 16'd2;
                        n_phase = (r_length == 16'd2) ? PH_CRC_LO : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_crc       = crc_byte(r_crc, d);
                    n_left      = r_left - 16'd1;
                    n_phase     = (r_left == 16'd1) ? PH_CRC_LO : PH_PAYLOAD;
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_DATA;
                    o_res.data  = d;
                end
                PH_CRC_LO: begin
                    n_low   = d;
                    n_phase = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    n_phase     = PH_HUNT;
                    o_res.valid = 1'b1;
                    o_res.kind  = (word == r_crc) ? KIND_GOOD : KIND_BAD;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end

        o_res.number = n_number;
        o_res.length = n_length;
        if (!i_en) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_esc    <= 1'b0;
            r_length <= '0;
            r_number <= '0;
            r_left   <= '0;
            r_crc    <= CRC_INIT;
            r_low    <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_esc    <= n_esc;
            r_length <= n_length;
            r_number <= n_number;
            r_left   <= n_left;
            r_crc    <= n_crc;
            r_low    <= n_low;
        end
    end

endmodule
`default_nettype wire
